@@ rtl/nfbsa_pkg.sv @@
// Shared types and constants for the next-fit bitmap slot allocator.
// No dependencies; the top level refers to this package by scoped names.
package nfbsa_pkg;

  localparam int SLOT_W     = 12;  // slot index field
  localparam int CNT_W      = 13;  // slot counts and internal flat indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic OP_TAKE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SLOTS = 1'd1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INACTIVE = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_DOUBLE   = 3'd4
  } status_t;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    status_t           status;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  total_slots;
  } rsp_t;

endpackage

@@ rtl/nfbsa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module nfbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/nfbsa_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Uses no package; divisor must be nonzero.
module nfbsa_div #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  dvd;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem, dvd[W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= {dvd[W-2:0], 1'b0};
      rem  <= fits ? W'(trial - {1'b0, dvs}) : trial[W-1:0];
      quot <= {quot[W-2:0], fits};
    end
  end

endmodule

@@ rtl/nfbsa_ffs.sv @@
// Find-first-set over one map word: lowest set bit of req.
// No dependencies.
module nfbsa_ffs #(
  parameter int W = 64
) (
  input  logic [W-1:0]  req,
  output logic          found,
  output logic [IW-1:0] idx
);
  localparam int IW = $clog2(W);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (req[b]) begin
        found = 1'b1;
        idx   = IW'(b);
      end
    end
  end

endmodule

@@ rtl/next_fit_bitmap_slot_allocator.sv @@
// Top level of the next-fit bitmap slot allocator: control FSM, map RAM, divider.
// Depends on nfbsa_pkg, nfbsa_ram, nfbsa_div, nfbsa_ffs.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | into      | in_valid/in_stall  | in_data  (req_t: op, slot)
//   out     | out of    | out_valid/out_stall| out_data (rsp_t)
//   cfg     | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request at a time. A take reads a map word (S_RD) and finds the first
// free bit in it (S_CHK), again for each further map word the scan visits.
// A next-fit pointer beyond a shrunken count is first taken modulo the count
// on the shared divider. A release, and a take after that modulo, split the
// slot into word/bit, on the divider when MAP_WORD_BITS is not a power of two.
// After reset the map RAM is swept to zero, one word a cycle, all MAP_WORDS
// words (64 by default), with in_stall high. Config writes are always taken.
// A result waiting on out_stall does not block the next transaction from
// being accepted; only its own result load waits.
module next_fit_bitmap_slot_allocator #(
  parameter int MAX_SLOTS     = 4096,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  nfbsa_pkg::req_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output nfbsa_pkg::rsp_t                      out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nfbsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nfbsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int  CNT_W     = nfbsa_pkg::CNT_W;
  localparam int  MAP_WORDS = (MAX_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int  WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int  BIT_W     = $clog2(MAP_WORD_BITS);
  localparam bit  POW2      = (MAP_WORD_BITS == (1 << BIT_W));
  localparam int  UC_W      = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV_MOD, S_SPLIT, S_DIV_SPLIT, S_RD, S_CHK, S_DONE
  } state_t;

  typedef enum logic [1:0] {CM_NONE, CM_TAKE, CM_REL} cmt_t;

  state_t state;

  // configuration
  logic             enabled;
  logic [CNT_W-1:0] num_slots;
  logic [CNT_W-1:0] total;

  // allocator state outside the map
  logic [UC_W-1:0]  used_counter;
  logic [CNT_W-1:0] ns_flat;   // next-fit pointer, flat and as word/bit pair
  logic [WA_W-1:0]  ns_word;
  logic [BIT_W-1:0] ns_bit;
  logic [CNT_W-1:0] ns_base;

  // per-transaction working registers
  logic             op_q;
  logic [CNT_W-1:0] split_val;
  logic [WA_W-1:0]  s_word;    // scan start word (target word on release)
  logic [BIT_W-1:0] s_bit;     // scan start bit (target bit on release)
  logic [WA_W-1:0]  cur_word;
  logic [CNT_W-1:0] cur_base;
  logic             wrapped;
  logic [WA_W-1:0]  clr_addr;

  // pending commit
  cmt_t                     cmt;
  nfbsa_pkg::status_t       res_status;
  logic [CNT_W-1:0]         res_granted;
  logic [MAP_WORD_BITS-1:0] wr_data;
  logic [CNT_W-1:0]         nx_flat;
  logic [WA_W-1:0]          nx_word;
  logic [BIT_W-1:0]         nx_bit;
  logic [CNT_W-1:0]         nx_base;

  // RAM and helpers
  logic                     ram_we;
  logic [WA_W-1:0]          ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic                     ram_re;
  logic [MAP_WORD_BITS-1:0] rd_data;

  logic             div_start;
  logic [CNT_W-1:0] div_dvd;
  logic [CNT_W-1:0] div_dvs;
  logic             div_busy;
  logic             div_done;
  logic [CNT_W-1:0] div_quot;
  logic [CNT_W-1:0] div_rem;

  logic [WA_W-1:0]  sp_word;
  logic [BIT_W-1:0] sp_bit;
  logic [CNT_W-1:0] sp_base;

  logic [MAP_WORD_BITS-1:0] scan_mask;
  logic [CNT_W-1:0]         lim;
  logic                     ffs_found;
  logic [BIT_W-1:0]         ffs_idx;
  logic [CNT_W-1:0]         gr_flat;
  logic [CNT_W:0]           next_base;
  logic                     at_start;

  logic                     in_acc;
  logic                     load;
  logic [UC_W-1:0]          uc_next;
  nfbsa_pkg::rsp_t          rsp_next;

  // effective count saturates at the map capacity
  assign total = (int'(num_slots) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : num_slots;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign load      = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b0;
      num_slots <= CNT_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nfbsa_pkg::REG_ENABLED:   enabled   <= cfg_data[0];
        nfbsa_pkg::REG_NUM_SLOTS: num_slots <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared divider: pointer modulo count, or index split by word size
  assign div_start = (in_acc && enabled && (in_data.op == nfbsa_pkg::OP_TAKE) &&
                      (total != '0) && (ns_flat >= total)) ||
                     ((state == S_SPLIT) && !POW2);
  assign div_dvd   = (state == S_IDLE) ? ns_flat : split_val;
  assign div_dvs   = (state == S_IDLE) ? total : CNT_W'(MAP_WORD_BITS);

  nfbsa_div #(.W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    if (POW2) begin
      sp_word = WA_W'(split_val >> BIT_W);
      sp_bit  = split_val[BIT_W-1:0];
    end else begin
      sp_word = WA_W'(div_quot);
      sp_bit  = BIT_W'(div_rem);
    end
    sp_base = split_val - CNT_W'(sp_bit);
  end

  // bits of the current word that the scan may take
  assign lim      = total - cur_base;
  assign at_start = (cur_word == s_word);

  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      scan_mask[b] = (CNT_W'(b) < lim);
      if (at_start && !wrapped && (BIT_W'(b) < s_bit)) scan_mask[b] = 1'b0;
      if (at_start && wrapped && (BIT_W'(b) >= s_bit)) scan_mask[b] = 1'b0;
    end
  end

  nfbsa_ffs #(.W(MAP_WORD_BITS)) u_ffs (
    .req   (~rd_data & scan_mask),
    .found (ffs_found),
    .idx   (ffs_idx)
  );

  assign gr_flat   = cur_base + CNT_W'(ffs_idx);
  assign next_base = {1'b0, cur_base} + (CNT_W + 1)'(MAP_WORD_BITS);

  // map RAM: clear sweep or commit write; reads only in S_RD, so a commit
  // write always lands before the next transaction reads
  assign ram_re    = (state == S_RD);
  assign ram_we    = (state == S_CLEAR) || ((state == S_DONE) && load && (cmt != CM_NONE));
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : cur_word;
  assign ram_wdata = (state == S_CLEAR) ? '0 : wr_data;

  nfbsa_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_word),
    .rdata (rd_data)
  );

  // counter after commit, and the result word
  always_comb begin
    uc_next = used_counter;
    case (cmt)
      CM_TAKE: if (used_counter < UC_W'(MAX_SLOTS)) uc_next = used_counter + 1'b1;
      CM_REL:  if (used_counter != '0) uc_next = used_counter - 1'b1;
      default: ;
    endcase
    rsp_next.granted_slot = res_granted[nfbsa_pkg::SLOT_W-1:0];
    rsp_next.status       = res_status;
    rsp_next.used_count   = CNT_W'(uc_next);
    rsp_next.total_slots  = total;
    if (res_status == nfbsa_pkg::ST_INACTIVE) begin
      rsp_next.used_count  = '0;
      rsp_next.total_slots = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      used_counter <= '0;
      ns_flat      <= '0;
      ns_word      <= '0;
      ns_bit       <= '0;
      ns_base      <= '0;
      cmt          <= CM_NONE;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WA_W'(MAP_WORDS - 1)) state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_acc) begin
            op_q        <= in_data.op;
            cmt         <= CM_NONE;
            res_granted <= '0;
            wrapped     <= 1'b0;
            if (!enabled) begin
              res_status <= nfbsa_pkg::ST_INACTIVE;
              state      <= S_DONE;
            end else if (in_data.op == nfbsa_pkg::OP_TAKE) begin
              if (total == '0) begin
                res_status <= nfbsa_pkg::ST_FULL;
                state      <= S_DONE;
              end else if (ns_flat < total) begin
                s_word   <= ns_word;
                s_bit    <= ns_bit;
                cur_word <= ns_word;
                cur_base <= ns_base;
                state    <= S_RD;
              end else begin
                state <= S_DIV_MOD;
              end
            end else begin
              if (CNT_W'(in_data.slot) >= total) begin
                res_status <= nfbsa_pkg::ST_RANGE;
                state      <= S_DONE;
              end else begin
                split_val <= CNT_W'(in_data.slot);
                state     <= S_SPLIT;
              end
            end
          end
        end

        S_DIV_MOD: begin
          if (div_done) begin
            split_val <= div_rem;
            state     <= S_SPLIT;
          end
        end

        S_SPLIT, S_DIV_SPLIT: begin
          if (POW2 || (state == S_DIV_SPLIT && div_done)) begin
            s_word   <= sp_word;
            s_bit    <= sp_bit;
            cur_word <= sp_word;
            cur_base <= sp_base;
            state    <= S_RD;
          end else if (state == S_SPLIT) begin
            state <= S_DIV_SPLIT;
          end
        end

        S_RD: state <= S_CHK;

        S_CHK: begin
          if (op_q == nfbsa_pkg::OP_TAKE) begin
            if (ffs_found) begin
              res_status  <= nfbsa_pkg::ST_OK;
              res_granted <= gr_flat;
              wr_data     <= rd_data | (MAP_WORD_BITS'(1) << ffs_idx);
              cmt         <= CM_TAKE;
              nx_flat     <= gr_flat + 1'b1;
              if (gr_flat + 1'b1 == total) begin
                nx_flat <= '0;
                nx_word <= '0;
                nx_bit  <= '0;
                nx_base <= '0;
              end else if (ffs_idx == BIT_W'(MAP_WORD_BITS - 1)) begin
                nx_word <= cur_word + 1'b1;
                nx_bit  <= '0;
                nx_base <= next_base[CNT_W-1:0];
              end else begin
                nx_word <= cur_word;
                nx_bit  <= ffs_idx + 1'b1;
                nx_base <= cur_base;
              end
              state <= S_DONE;
            end else if (wrapped && at_start) begin
              res_status <= nfbsa_pkg::ST_FULL;
              state      <= S_DONE;
            end else begin
              // next word, wrapping past the last word in use
              if (next_base >= {1'b0, total}) begin
                cur_word <= '0;
                cur_base <= '0;
                wrapped  <= 1'b1;
              end else begin
                cur_word <= cur_word + 1'b1;
                cur_base <= next_base[CNT_W-1:0];
              end
              state <= S_RD;
            end
          end else begin
            if (rd_data[s_bit]) begin
              res_status <= nfbsa_pkg::ST_OK;
              wr_data    <= rd_data & ~(MAP_WORD_BITS'(1) << s_bit);
              cmt        <= CM_REL;
            end else begin
              res_status <= nfbsa_pkg::ST_DOUBLE;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (load) begin
            out_valid    <= 1'b1;
            out_data     <= rsp_next;
            used_counter <= uc_next;
            if (cmt == CM_TAKE) begin
              ns_flat <= nx_flat;
              ns_word <= nx_word;
              ns_bit  <= nx_bit;
              ns_base <= nx_base;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != S_IDLE))
    else $error("accepted transaction left the FSM idle");

  a_ptr_pair: assert property (@(posedge clk) disable iff (rst)
    ns_flat == ns_base + CNT_W'(ns_bit))
    else $error("next-fit pointer word/bit pair out of step with flat index");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_counter <= UC_W'(MAX_SLOTS))
    else $error("used counter above capacity");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_MOD || state == S_DIV_SPLIT))
    else $error("divider finished with no state waiting on it");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != cur_word))
    else $error("map read and write to the same word in one cycle");
`endif

endmodule
